### rtl/core/rdsm_pkg.sv
// Shared types and constants for the dot/star regular expression matcher.
// No dependencies; rdsm_ifs and the matcher top refer to it by scoped name.
`timescale 1ns / 1ps

package rdsm_pkg;

    typedef logic [1:0] func_t;
    typedef logic [7:0] byte_t;

    localparam func_t FUNC_BEGIN_PATTERN = 2'd0;
    localparam func_t FUNC_APPEND_BYTE   = 2'd1;
    localparam func_t FUNC_BEGIN_TEXT    = 2'd2;
    localparam func_t FUNC_TEXT_BYTE     = 2'd3;

    localparam byte_t STAR_BYTE = 8'h2A;
    localparam byte_t DOT_BYTE  = 8'h2E;

endpackage

### rtl/core/rdsm_ifs.sv
// Valid/ready channel interfaces for the matcher: command beats in, results out.
// Depends on rdsm_pkg for the payload types.
`timescale 1ns / 1ps

interface rdsm_req_if;
    logic            valid;
    logic            ready;
    rdsm_pkg::func_t func;
    rdsm_pkg::byte_t byte_value;

    modport source (output valid, output func, output byte_value, input ready);
    modport sink   (input valid, input func, input byte_value, output ready);
endinterface

interface rdsm_resp_if;
    logic valid;
    logic ready;
    logic full_match;
    logic pattern_overflow;

    modport source (output valid, output full_match, output pattern_overflow, input ready);
    modport sink   (input valid, input full_match, input pattern_overflow, output ready);
endinterface

### rtl/core/rdsm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module rdsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/regex_dot_star_matcher.sv
// Top level of the dot/star whole-string matcher: sequencer over pattern and row RAMs.
// Depends on rdsm_pkg, rdsm_ifs (channel interfaces) and rdsm_ram.
//
//   channel | role | payload                          | beat
//   req     | sink | func, byte_value                 | one command
//   resp    | src  | full_match, pattern_overflow     | one result (begin text, text byte)
//
// Begin pattern and append give no result.
// Begin text and text byte each give one result, after one read of
// the pattern RAM and one read-modify-write of the row RAM per pattern position.
// Reset clears length, overflow and the row watermark; both RAMs need no clearing,
// row entries above the watermark read as zero.
// A held result stalls a new text command only at its end, when the result
// register is still occupied.
`timescale 1ns / 1ps

module regex_dot_star_matcher #(
    parameter int PATTERN_MAX = 64
) (
    input  logic  clk,
    input  logic  rst_n,
    rdsm_req_if.sink    req,
    rdsm_resp_if.source resp
);

    localparam int LW  = $clog2(PATTERN_MAX + 1);
    localparam int PAW = $clog2(PATTERN_MAX);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]      state_reg, state_next;
    logic [LW-1:0]   j_reg;
    logic [LW-1:0]   len_reg;
    logic [LW-1:0]   w_reg;
    logic            ovf_reg;
    logic            row0_reg;
    logic            mode_begin_reg;
    rdsm_pkg::byte_t c_reg;
    rdsm_pkg::byte_t prev_pat_reg;
    logic            old_prev_reg;
    logic            nx1_reg;
    logic            nx2_reg;
    logic            res_reg;
    logic            out_valid_reg;
    logic            out_match_reg;
    logic            out_ovf_reg;

    logic            accept;
    logic            text_cmd;
    logic            pat_we;
    logic [PAW-1:0]  pat_raddr;
    rdsm_pkg::byte_t pat_rdata;
    logic            row_we;
    logic [LW-1:0]   row_raddr;
    logic            row_rdata;
    logic [LW:0]     j_plus;
    logic            row_old;
    logic            star;
    logic            fits_cur;
    logic            fits_prev;
    logic            nxt;
    logic            last;
    logic            deliver;
    logic [LW-1:0]   w_begin;

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign text_cmd = (req.func == rdsm_pkg::FUNC_BEGIN_TEXT) ||
                      (req.func == rdsm_pkg::FUNC_TEXT_BYTE);

    assign pat_we    = accept && (req.func == rdsm_pkg::FUNC_APPEND_BYTE) &&
                       (len_reg < LW'(PATTERN_MAX));
    assign pat_raddr = (state_reg == ST_RUN) ? j_reg[PAW-1:0] : '0;

    assign j_plus    = {1'b0, j_reg} + (LW+1)'(1);
    assign row_raddr = (state_reg == ST_RUN) ? j_plus[LW-1:0] : LW'(1);
    assign row_we    = (state_reg == ST_RUN);

    rdsm_ram #(
        .WIDTH (8),
        .DEPTH (PATTERN_MAX)
    ) u_pattern_ram (
        .clk   (clk),
        .we    (pat_we),
        .waddr (len_reg[PAW-1:0]),
        .wdata (req.byte_value),
        .raddr (pat_raddr),
        .rdata (pat_rdata)
    );

    rdsm_ram #(
        .WIDTH (1),
        .DEPTH (PATTERN_MAX + 1)
    ) u_row_ram (
        .clk   (clk),
        .we    (row_we),
        .waddr (j_reg),
        .wdata (nxt),
        .raddr (row_raddr),
        .rdata (row_rdata)
    );

    // entries above the watermark were never built or were cleared by an advance
    assign row_old   = (j_reg <= w_reg) ? row_rdata : 1'b0;
    assign star      = (j_reg > LW'(1)) && (pat_rdata == rdsm_pkg::STAR_BYTE);
    assign fits_cur  = (pat_rdata == rdsm_pkg::DOT_BYTE) || (pat_rdata == c_reg);
    assign fits_prev = (prev_pat_reg == rdsm_pkg::DOT_BYTE) || (prev_pat_reg == c_reg);
    assign last      = (j_reg == len_reg);
    assign w_begin   = (len_reg > w_reg) ? len_reg : w_reg;
    assign deliver   = (state_reg == ST_DONE) && (!out_valid_reg || resp.ready);

    always_comb
    begin
        if (mode_begin_reg)
        begin
            nxt = star ? nx2_reg : 1'b0;
        end
        else if (star)
        begin
            nxt = (fits_prev && row_old) || nx2_reg;
        end
        else
        begin
            nxt = fits_cur && old_prev_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && text_cmd)
                begin
                    state_next = (len_reg == '0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (deliver)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            w_reg         <= '0;
            ovf_reg       <= 1'b0;
            row0_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                unique case (req.func)
                    rdsm_pkg::FUNC_BEGIN_PATTERN:
                    begin
                        len_reg <= '0;
                        ovf_reg <= 1'b0;
                    end
                    rdsm_pkg::FUNC_APPEND_BYTE:
                    begin
                        if (len_reg < LW'(PATTERN_MAX))
                        begin
                            len_reg <= len_reg + LW'(1);
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    rdsm_pkg::FUNC_BEGIN_TEXT:
                    begin
                        row0_reg <= 1'b1;
                    end
                    rdsm_pkg::FUNC_TEXT_BYTE:
                    begin
                        row0_reg <= 1'b0;
                    end
                    default:
                    begin
                        row0_reg <= row0_reg;
                    end
                endcase
            end
            if (deliver)
            begin
                w_reg         <= mode_begin_reg ? w_begin : len_reg;
                out_valid_reg <= 1'b1;
            end
            else if (resp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // per-position datapath registers
    always_ff @(posedge clk)
    begin
        if (accept && text_cmd)
        begin
            mode_begin_reg <= (req.func == rdsm_pkg::FUNC_BEGIN_TEXT);
            c_reg          <= req.byte_value;
            j_reg          <= LW'(1);
            old_prev_reg   <= row0_reg;
            nx1_reg        <= (req.func == rdsm_pkg::FUNC_BEGIN_TEXT);
            nx2_reg        <= 1'b0;
            res_reg        <= (req.func == rdsm_pkg::FUNC_BEGIN_TEXT);
        end
        else if (state_reg == ST_RUN)
        begin
            prev_pat_reg <= pat_rdata;
            old_prev_reg <= row_old;
            nx2_reg      <= nx1_reg;
            nx1_reg      <= nxt;
            res_reg      <= nxt;
            j_reg        <= j_plus[LW-1:0];
        end
        if (deliver)
        begin
            out_match_reg <= res_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign resp.valid            = out_valid_reg;
    assign resp.full_match       = out_match_reg;
    assign resp.pattern_overflow = out_ovf_reg;

    a_run_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (j_reg >= LW'(1)) && (j_reg <= len_reg))
        else $error("row index outside pattern during sweep");

    a_row_write_not_zero: assert property (@(posedge clk) disable iff (!rst_n)
        row_we |-> (j_reg != '0))
        else $error("row RAM written at position zero");

    a_watermark_bound: assert property (@(posedge clk) disable iff (!rst_n)
        w_reg <= LW'(PATTERN_MAX))
        else $error("row watermark beyond capacity");

    a_len_stable_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |=> $stable(len_reg))
        else $error("pattern length changed during a sweep");

    a_deliver_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        deliver |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("finished result not placed in output register");

endmodule
